// File: sv/esc_pkg.sv
// shared types and constants for the epoch seconds to calendar converter
// no dependencies
package esc_pkg;

   localparam int SecsPerMinute = 60;
   localparam int SecsPerHour   = 3600;
   localparam int SecsPerDay    = 86400;
   localparam int ZoneOffset    = 8 * SecsPerHour;
   localparam int EpochYear     = 1970;

   localparam int InWidth     = 31;
   localparam int TimeWidth   = 32;
   localparam int YearWidth   = 11;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int MinuteWidth = 6;
   localparam int SecondWidth = 6;
   localparam int Cnt100Width = 7;
   localparam int Cnt400Width = 9;

   localparam logic [TimeWidth-1:0] CommonYearSecs = TimeWidth'(365 * SecsPerDay);
   localparam logic [TimeWidth-1:0] LeapYearSecs   = TimeWidth'(366 * SecsPerDay);
   localparam logic [TimeWidth-1:0] DaySecs        = TimeWidth'(SecsPerDay);
   localparam logic [TimeWidth-1:0] HourSecs       = TimeWidth'(SecsPerHour);
   localparam logic [TimeWidth-1:0] MinuteSecs     = TimeWidth'(SecsPerMinute);
   localparam logic [TimeWidth-1:0] ZoneSecs       = TimeWidth'(ZoneOffset);

   localparam logic [YearWidth-1:0]   YearStart   = YearWidth'(EpochYear);
   localparam logic [Cnt100Width-1:0] Cnt100Start = Cnt100Width'(EpochYear % 100);
   localparam logic [Cnt400Width-1:0] Cnt400Start = Cnt400Width'(EpochYear % 400);
   localparam logic [Cnt100Width-1:0] Cnt100Last  = Cnt100Width'(99);
   localparam logic [Cnt400Width-1:0] Cnt400Last  = Cnt400Width'(399);

   localparam logic [MonthWidth-1:0] MonthJan = 4'd0;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd1;
   localparam logic [MonthWidth-1:0] MonthApr = 4'd3;
   localparam logic [MonthWidth-1:0] MonthJun = 4'd5;
   localparam logic [MonthWidth-1:0] MonthSep = 4'd8;
   localparam logic [MonthWidth-1:0] MonthNov = 4'd10;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd11;

   typedef enum logic [2:0] {
      PH_YEAR   = 3'd0,
      PH_MONTH  = 3'd1,
      PH_DAY    = 3'd2,
      PH_HOUR   = 3'd3,
      PH_MINUTE = 3'd4
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      step;
      logic      publish;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic ge;
      logic month_last;
   } status_type;

   // month length in seconds, month index from zero
   function automatic logic [TimeWidth-1:0] month_secs(input logic [MonthWidth-1:0] month,
                                                      input logic leap);
      logic [TimeWidth-1:0] secs;
      secs = TimeWidth'(31 * SecsPerDay);
      case (month)
         MonthFeb: begin
            secs = leap ? TimeWidth'(29 * SecsPerDay) : TimeWidth'(28 * SecsPerDay);
         end
         MonthApr, MonthJun, MonthSep, MonthNov: begin
            secs = TimeWidth'(30 * SecsPerDay);
         end
         default: begin
            secs = TimeWidth'(31 * SecsPerDay);
         end
      endcase
      return secs;
   endfunction

endpackage

// File: sv/epoch_seconds_to_calendar.sv
// epoch_seconds_to_calendar: seconds since 1970-01-01 00:00:00 utc to the
// calendar date and time at utc plus eight hours
// top level; depends on esc_pkg, esc_ctrl and esc_datapath
//
// req_ channel takes one 31-bit seconds count per transaction; rsp_ channel
// returns year, month, day, hour, minute and second, one result per request.
// the conversion subtracts whole years, months, days, hours and minutes from
// the remaining time, one unit per cycle, through a single compare-subtract
// unit. the next request can be taken in the cycle after the result is
// published. one request is converted at a time; req_ready is high only
// while idle. the result sits in an output register, so the next request
// is taken while a finished result still waits; if rsp_ready stays low the
// next conversion stops at its end until the register frees up.
// reset returns the controller to idle and drops rsp_valid; there is no other
// state to clear.
module epoch_seconds_to_calendar
   import esc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [InWidth-1:0]     req_epoch_seconds,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [YearWidth-1:0]   rsp_cal_year,
   output logic [MonthWidth-1:0]  rsp_cal_month,
   output logic [DayWidth-1:0]    rsp_cal_day,
   output logic [HourWidth-1:0]   rsp_cal_hour,
   output logic [MinuteWidth-1:0] rsp_cal_minute,
   output logic [SecondWidth-1:0] rsp_cal_second
);

   cmd_type    cmd;
   status_type status;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   esc_datapath u_datapath (
      .clock             (clock),
      .req_epoch_seconds (req_epoch_seconds),
      .cmd               (cmd),
      .status            (status),
      .rsp_cal_year      (rsp_cal_year),
      .rsp_cal_month     (rsp_cal_month),
      .rsp_cal_day       (rsp_cal_day),
      .rsp_cal_hour      (rsp_cal_hour),
      .rsp_cal_minute    (rsp_cal_minute),
      .rsp_cal_second    (rsp_cal_second)
   );

endmodule

// File: sv/esc_datapath.sv
// datapath of the epoch seconds converter: remaining-time register, field counters
// and result registers; depends on esc_pkg, driven by esc_ctrl commands
module esc_datapath
   import esc_pkg::*;
(
   input  logic                   clock,
   input  logic [InWidth-1:0]     req_epoch_seconds,
   input  cmd_type                cmd,
   output status_type             status,
   output logic [YearWidth-1:0]   rsp_cal_year,
   output logic [MonthWidth-1:0]  rsp_cal_month,
   output logic [DayWidth-1:0]    rsp_cal_day,
   output logic [HourWidth-1:0]   rsp_cal_hour,
   output logic [MinuteWidth-1:0] rsp_cal_minute,
   output logic [SecondWidth-1:0] rsp_cal_second
);

   logic [TimeWidth-1:0]   t_ff, t_in;
   logic [YearWidth-1:0]   year_ff, year_in;
   logic [Cnt100Width-1:0] c100_ff, c100_in;
   logic [Cnt400Width-1:0] c400_ff, c400_in;
   logic [MonthWidth-1:0]  month_ff, month_in;
   logic [DayWidth-1:0]    day_ff, day_in;
   logic [HourWidth-1:0]   hour_ff, hour_in;
   logic [MinuteWidth-1:0] minute_ff, minute_in;

   logic [YearWidth-1:0]   out_year_ff, out_year_in;
   logic [MonthWidth-1:0]  out_month_ff, out_month_in;
   logic [DayWidth-1:0]    out_day_ff, out_day_in;
   logic [HourWidth-1:0]   out_hour_ff, out_hour_in;
   logic [MinuteWidth-1:0] out_minute_ff, out_minute_in;
   logic [SecondWidth-1:0] out_second_ff, out_second_in;

   logic                 leap;
   logic [TimeWidth-1:0] unit;

   // 4/100/400 rule from the low year bits and the two wrap counters
   assign leap = ((year_ff[1:0] == 2'd0) && (c100_ff != '0)) || (c400_ff == '0);

   always_comb begin
      case (cmd.phase)
         PH_YEAR:   unit = leap ? LeapYearSecs : CommonYearSecs;
         PH_MONTH:  unit = month_secs(month_ff, leap);
         PH_DAY:    unit = DaySecs;
         PH_HOUR:   unit = HourSecs;
         PH_MINUTE: unit = MinuteSecs;
         default:   unit = MinuteSecs;
      endcase
   end

   assign status.ge         = (t_ff >= unit);
   assign status.month_last = (month_ff == MonthDec);

   always_comb begin
      t_in      = t_ff;
      year_in   = year_ff;
      c100_in   = c100_ff;
      c400_in   = c400_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      if (cmd.load) begin
         t_in      = TimeWidth'(req_epoch_seconds) + ZoneSecs;
         year_in   = YearStart;
         c100_in   = Cnt100Start;
         c400_in   = Cnt400Start;
         month_in  = MonthJan;
         day_in    = '0;
         hour_in   = '0;
         minute_in = '0;
      end else if (cmd.step) begin
         t_in = t_ff - unit;
         case (cmd.phase)
            PH_YEAR: begin
               year_in = year_ff + 1'b1;
               c100_in = (c100_ff == Cnt100Last) ? '0 : c100_ff + 1'b1;
               c400_in = (c400_ff == Cnt400Last) ? '0 : c400_ff + 1'b1;
            end
            PH_MONTH:  month_in  = month_ff + 1'b1;
            PH_DAY:    day_in    = day_ff + 1'b1;
            PH_HOUR:   hour_in   = hour_ff + 1'b1;
            PH_MINUTE: minute_in = minute_ff + 1'b1;
            default:   t_in      = t_ff;
         endcase
      end
   end

   always_comb begin
      out_year_in   = out_year_ff;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      out_hour_in   = out_hour_ff;
      out_minute_in = out_minute_ff;
      out_second_in = out_second_ff;
      if (cmd.publish) begin
         out_year_in   = year_ff;
         out_month_in  = month_ff + 1'b1;
         out_day_in    = day_ff + 1'b1;
         out_hour_in   = hour_ff;
         out_minute_in = minute_ff;
         // after the minute phase less than a minute is left
         out_second_in = t_ff[SecondWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      year_ff       <= year_in;
      c100_ff       <= c100_in;
      c400_ff       <= c400_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_cal_year   = out_year_ff;
   assign rsp_cal_month  = out_month_ff;
   assign rsp_cal_day    = out_day_ff;
   assign rsp_cal_hour   = out_hour_ff;
   assign rsp_cal_minute = out_minute_ff;
   assign rsp_cal_second = out_second_ff;

endmodule

// File: sv/esc_ctrl.sv
// controller of the epoch seconds converter: phase sequencing and handshakes
// depends on esc_pkg; commands esc_datapath
module esc_ctrl
   import esc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_YEAR   = 7'b0000010,
      ST_MONTH  = 7'b0000100,
      ST_DAY    = 7'b0001000,
      ST_HOUR   = 7'b0010000,
      ST_MINUTE = 7'b0100000,
      ST_FIN    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.publish = 1'b0;
      cmd.phase   = PH_YEAR;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            cmd.phase = PH_YEAR;
            if (status.ge) cmd.step = 1'b1;
            else state_in = ST_MONTH;
         end
         ST_MONTH: begin
            cmd.phase = PH_MONTH;
            // december takes whatever is left
            if (status.ge && !status.month_last) cmd.step = 1'b1;
            else state_in = ST_DAY;
         end
         ST_DAY: begin
            cmd.phase = PH_DAY;
            if (status.ge) cmd.step = 1'b1;
            else state_in = ST_HOUR;
         end
         ST_HOUR: begin
            cmd.phase = PH_HOUR;
            if (status.ge) cmd.step = 1'b1;
            else state_in = ST_MINUTE;
         end
         ST_MINUTE: begin
            cmd.phase = PH_MINUTE;
            if (status.ge) cmd.step = 1'b1;
            else state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait for the result register to free up
            if (!out_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_valid_in = cmd.publish | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   a_accept_starts_year: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_YEAR)
      else $error("accepted transaction did not start the year phase");

   a_publish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("published result not offered");

   a_fin_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && rsp_valid && !rsp_ready |=> state_ff == ST_FIN)
      else $error("result register overwritten while stalled");

   a_december_ends_months: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MONTH && status.month_last |=> state_ff == ST_DAY)
      else $error("month phase ran past december");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for epoch_seconds_to_calendar: directed calendar edges,
// then random timestamps checked against an in-bench calendar conversion
// depends on esc_pkg and the epoch_seconds_to_calendar rtl
module tb_top;
   import esc_pkg::*;

   localparam int unsigned MaxSecs      = 32'h7FFF_FFFF;
   localparam int unsigned RandomItems  = 1600;
   localparam int unsigned HoldCycles   = 400;
   localparam int unsigned SettleCycles = 250;
   localparam int unsigned CycleLimit   = 3_000_000;
   localparam int unsigned LastYear     = 2038;

   typedef struct packed {
      logic [YearWidth-1:0]   year;
      logic [MonthWidth-1:0]  month;
      logic [DayWidth-1:0]    day;
      logic [HourWidth-1:0]   hour;
      logic [MinuteWidth-1:0] minute;
      logic [SecondWidth-1:0] second;
   } calendar_type;

   typedef struct {
      logic [InWidth-1:0] secs;
      calendar_type       cal;
   } due_date_type;

   class calendar_book_type;
      due_date_type due[$];
      int unsigned  failures;
      int unsigned  matched;

      static function bit is_leap(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      // days in month, month index from zero
      static function int unsigned month_len(int unsigned m, bit leap);
         int unsigned n;
         case (MonthWidth'(m))
            MonthFeb: begin
               n = leap ? 29 : 28;
            end
            MonthApr, MonthJun, MonthSep, MonthNov: begin
               n = 30;
            end
            default: begin
               n = 31;
            end
         endcase
         return n;
      endfunction

      static function calendar_type to_calendar(logic [InWidth-1:0] secs);
         calendar_type    c;
         longint unsigned local_secs;
         int unsigned     days;
         int unsigned     in_day;
         int unsigned     year;
         int unsigned     month;
         bit              leap;
         local_secs = longint'(secs) + ZoneOffset;
         days       = int'(local_secs / SecsPerDay);
         in_day     = int'(local_secs % SecsPerDay);
         year       = EpochYear;
         // each year at its own length, leap years included
         while (days >= (is_leap(year) ? 366 : 365)) begin
            days -= is_leap(year) ? 366 : 365;
            year++;
         end
         leap  = is_leap(year);
         month = 0;
         while (month < 11 && days >= month_len(month, leap)) begin
            days -= month_len(month, leap);
            month++;
         end
         c.year   = YearWidth'(year);
         c.month  = MonthWidth'(month + 1);
         c.day    = DayWidth'(days + 1);
         c.hour   = HourWidth'(in_day / SecsPerHour);
         c.minute = MinuteWidth'((in_day % SecsPerHour) / SecsPerMinute);
         c.second = SecondWidth'(in_day % SecsPerMinute);
         return c;
      endfunction

      function void note_request(logic [InWidth-1:0] secs);
         due_date_type d;
         d.secs = secs;
         d.cal  = to_calendar(secs);
         due.push_back(d);
      endfunction

      function int unsigned pending();
         return due.size();
      endfunction

      function void report(string msg);
         failures++;
         $display("%0t ERROR %s", $time, msg);
      endfunction

      function bit compare_field(string name, logic [InWidth-1:0] secs,
                                 int unsigned want, int unsigned got);
         if (want == got) begin
            return 1'b0;
         end
         report($sformatf("%s for %0d: expected %0d, actual %0d", name, secs, want, got));
         return 1'b1;
      endfunction

      function void check_result(calendar_type got);
         due_date_type d;
         bit           bad;
         if (due.size() == 0) begin
            report($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                             got.day, got.hour, got.minute, got.second));
            return;
         end
         d   = due.pop_front();
         bad = 1'b0;
         bad |= compare_field("year", d.secs, d.cal.year, got.year);
         bad |= compare_field("month", d.secs, d.cal.month, got.month);
         bad |= compare_field("day", d.secs, d.cal.day, got.day);
         bad |= compare_field("hour", d.secs, d.cal.hour, got.hour);
         bad |= compare_field("minute", d.secs, d.cal.minute, got.minute);
         bad |= compare_field("second", d.secs, d.cal.second, got.second);
         if (!bad) begin
            matched++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [InWidth-1:0]     req_epoch_seconds = '0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [YearWidth-1:0]   rsp_cal_year;
   logic [MonthWidth-1:0]  rsp_cal_month;
   logic [DayWidth-1:0]    rsp_cal_day;
   logic [HourWidth-1:0]   rsp_cal_hour;
   logic [MinuteWidth-1:0] rsp_cal_minute;
   logic [SecondWidth-1:0] rsp_cal_second;

   bit                     calm         = 1'b0;
   bit                     hold_request = 1'b0;
   int unsigned            sent         = 0;
   int unsigned            edge_items   = 0;
   int unsigned            input_stalls = 0;
   calendar_book_type      book         = new();

   epoch_seconds_to_calendar DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cal_year      (rsp_cal_year),
      .rsp_cal_month     (rsp_cal_month),
      .rsp_cal_day       (rsp_cal_day),
      .rsp_cal_hour      (rsp_cal_hour),
      .rsp_cal_minute    (rsp_cal_minute),
      .rsp_cal_second    (rsp_cal_second)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CycleLimit) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding", CycleLimit, book.pending());
      $display("FAIL epoch_seconds_to_calendar");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         book.check_result({rsp_cal_year, rsp_cal_month, rsp_cal_day,
                            rsp_cal_hour, rsp_cal_minute, rsp_cal_second});
      end
      if (!reset && req_valid && !req_ready) begin
         input_stalls++;
      end
   end

   // result side: random backpressure, calm stretches and one long hold-off
   initial begin : rsp_side
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 24);
         end
      end
   end

   // local midnight (utc plus eight) of a calendar date as epoch seconds
   function automatic longint local_midnight(int unsigned y, int unsigned m, int unsigned d);
      longint      days;
      int unsigned yy;
      int unsigned mm;
      days = longint'(d) - 1;
      for (yy = EpochYear; yy < y; yy++) begin
         days += calendar_book_type::is_leap(yy) ? 366 : 365;
      end
      for (mm = 0; mm + 1 < m; mm++) begin
         days += calendar_book_type::month_len(mm, calendar_book_type::is_leap(y));
      end
      return days * SecsPerDay - ZoneOffset;
   endfunction

   function automatic logic [InWidth-1:0] clamp_secs(longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > longint'(MaxSecs)) begin
         return InWidth'(MaxSecs);
      end
      return InWidth'(v);
   endfunction

   // expects to start at a falling edge and returns at one
   task automatic send_request(input logic [InWidth-1:0] secs);
      while (!calm && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(secs);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (book.pending() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      longint      edges[$];
      int unsigned n;
      int unsigned y;
      int unsigned m;
      longint      offset;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      edges = '{0, 1, longint'(MaxSecs), 64'h4000_0000, 64'h2AAA_AAAA, 64'h5555_5555,
                57599, 57600,
                local_midnight(1971, 1, 1) - 1, local_midnight(1971, 1, 1),
                local_midnight(1972, 2, 29), local_midnight(1972, 3, 1) - 1,
                local_midnight(1972, 12, 31) + 3600, local_midnight(1973, 1, 1),
                local_midnight(1973, 3, 1) - 1,
                local_midnight(2000, 1, 1) - 1, local_midnight(2000, 2, 29) + 43200,
                local_midnight(2000, 3, 1) - 1, local_midnight(2000, 12, 31) + 86399,
                local_midnight(2038, 1, 19), local_midnight(2038, 1, 19) - 1};
      foreach (edges[i]) begin
         send_request(clamp_secs(edges[i]));
      end
      wait_for_results();

      for (n = 0; n < RandomItems; n++) begin
         if (n == 300) calm = 1'b1;
         if (n == 550) calm = 1'b0;
         if (n == 800) hold_request = 1'b1;
         if (n == 1200) wait_for_results();
         if ($urandom_range(99) < 55) begin
            send_request(InWidth'($urandom_range(0, MaxSecs)));
         end else begin
            // near a month boundary, often within a minute of midnight
            y = $urandom_range(EpochYear, LastYear);
            m = (y == LastYear) ? 1 : $urandom_range(1, 12);
            if ($urandom_range(1)) begin
               offset = longint'($urandom_range(0, 120)) - 60;
            end else begin
               offset = longint'($urandom_range(0, 2 * SecsPerDay)) - SecsPerDay;
            end
            edge_items++;
            send_request(clamp_secs(local_midnight(y, m, 1) + offset));
         end
      end

      wait_for_results();
      repeat (SettleCycles) @(negedge clock);

      $display("converted %0d timestamps (%0d directed, %0d near month edges), %0d matched",
               sent, edges.size(), edge_items, book.matched);
      $display("input held off for %0d cycles by backpressure, %0d errors",
               input_stalls, book.failures);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("PASS epoch_seconds_to_calendar");
      end else begin
         $display("FAIL epoch_seconds_to_calendar");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/esc_pkg.sv
sv/esc_datapath.sv
sv/esc_ctrl.sv
sv/epoch_seconds_to_calendar.sv
tb/tb_top.sv
